>>> design/qtic_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the quad to triangle index converter.
// Used by every module of the block; depends on nothing.
package qtic_pkg;

  localparam int INDEX_BITS  = 16;              // source index truncation width
  localparam int IDX_W       = 16;              // emitted index width
  localparam int QUAD_IN     = 4;
  localparam int QUAD_OUT    = 6;
  localparam int QDEPTH      = 2;               // front/back queue depth
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INDEXED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX = 2'd2;

  // index size codes
  localparam logic [1:0] BYTES_ONE = 2'd0;

  typedef struct packed {
    logic [31:0] index_value;
    logic        last_in;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic             index_valid;
    logic             last_out;
    logic [IDX_W-1:0] min_seen;
    logic [IDX_W-1:0] max_seen;
  } out_word_t;

  typedef struct packed {
    logic                   indexed_mode;
    logic [1:0]             index_bytes_code;
    logic [IDX_W-1:0]       start_vertex;
  } cfg_t;

  // one unit of work for the back end: a full quad or a bare end marker
  typedef struct packed {
    logic [QUAD_IN-1:0][IDX_W-1:0] slots;
    logic                          is_quad;
    logic                          last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // slot order of the two triangles: v0,v1,v2,v0,v2,v3
  function automatic logic [1:0] slot_sel(input logic [2:0] step);
    logic [1:0] s;
    unique case (step)
      3'd0:    s = 2'd0;
      3'd1:    s = 2'd1;
      3'd2:    s = 2'd2;
      3'd3:    s = 2'd0;
      3'd4:    s = 2'd2;
      3'd5:    s = 2'd3;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

>>> design/qtic_front.sv
`timescale 1ns / 1ps
// Front end: accepts vertex slot words, forms slot indices and gathers quads.
// Depends on qtic_pkg.
module qtic_front (
  input  logic              clk,
  input  logic              rst_n,
  input  qtic_pkg::cfg_t    cfg,
  input  logic              acc,
  input  qtic_pkg::in_word_t in_word,
  output logic              push,
  output qtic_pkg::job_t    push_job
);

  logic                          first_r, first_nxt;
  logic [qtic_pkg::IDX_W-1:0]    seq_r, seq_nxt;
  logic [1:0]                    cnt_r, cnt_nxt;
  logic [qtic_pkg::IDX_W-1:0]    slot_r [3];
  logic [qtic_pkg::IDX_W-1:0]    seq_base;
  logic [31:0]                   masked;
  logic [qtic_pkg::IDX_W-1:0]    v;
  logic                          quad_done;

  always_comb begin
    seq_base = first_r ? cfg.start_vertex : seq_r;
    masked   = in_word.index_value & qtic_pkg::IDX_MASK;
    if (cfg.indexed_mode) begin
      if (cfg.index_bytes_code == qtic_pkg::BYTES_ONE) begin
        v = {8'd0, in_word.index_value[7:0]};
      end else begin
        v = masked[qtic_pkg::IDX_W-1:0];
      end
    end else begin
      v = seq_base;
    end
    quad_done = (cnt_r == 2'd3);
    push      = acc && (quad_done || in_word.last_in);

    push_job.slots   = {v, slot_r[2], slot_r[1], slot_r[0]};
    push_job.is_quad = quad_done;
    push_job.last    = in_word.last_in;

    seq_nxt   = seq_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    if (acc) begin
      seq_nxt   = seq_base + 16'd1;
      cnt_nxt   = (quad_done || in_word.last_in) ? 2'd0 : cnt_r + 2'd1;
      first_nxt = in_word.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      seq_r   <= '0;
      cnt_r   <= '0;
    end else begin
      first_r <= first_nxt;
      seq_r   <= seq_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // hold partial quad slots; the fourth slot goes straight into the job
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (acc && cnt_r == 2'(i)) begin
        slot_r[i] <= v;
      end
    end
  end

endmodule

>>> design/qtic_queue.sv
`timescale 1ns / 1ps
// Short job queue between front and back end.
// Depends on qtic_pkg.
module qtic_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qtic_pkg::job_t   push_job,
  input  logic             pop,
  output qtic_pkg::job_t   head,
  output qtic_pkg::q_stat_t stat
);

  localparam int PW = $clog2(qtic_pkg::QDEPTH);
  localparam int CW = $clog2(qtic_pkg::QDEPTH + 1);

  qtic_pkg::job_t mem_r [qtic_pkg::QDEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    stat.full  = (cnt_r == CW'(qtic_pkg::QDEPTH));
    stat.empty = (cnt_r == '0);
    head       = mem_r[rd_r];
    wr_nxt     = wr_r;
    rd_nxt     = rd_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(qtic_pkg::QDEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(qtic_pkg::QDEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

>>> design/qtic_back.sv
`timescale 1ns / 1ps
// Back end: walks each job into result words, tracks draw min/max, owns the output register.
// Depends on qtic_pkg.
module qtic_back (
  input  logic               clk,
  input  logic               rst_n,
  input  qtic_pkg::job_t     head,
  input  qtic_pkg::q_stat_t  stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output qtic_pkg::out_word_t out_data
);

  logic [2:0]                 step_r, step_nxt;
  logic [qtic_pkg::IDX_W-1:0] min_r, min_nxt, max_r, max_nxt;
  logic                       any_r, any_nxt;
  logic                       valid_r, valid_nxt;
  qtic_pkg::out_word_t        data_r, data_nxt;
  logic                       load, fire, final_step;
  logic [qtic_pkg::IDX_W-1:0] idx, new_min, new_max;

  always_comb begin
    load       = !valid_r || out_ready;
    fire       = load && !stat.empty;
    final_step = (step_r == 3'(qtic_pkg::QUAD_OUT - 1));
    pop        = fire && (!head.is_quad || final_step);

    idx     = head.slots[qtic_pkg::slot_sel(step_r)];
    new_min = (idx < min_r) ? idx : min_r;
    new_max = (idx > max_r) ? idx : max_r;

    step_nxt  = step_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    any_nxt   = any_r;
    data_nxt  = data_r;
    valid_nxt = load ? 1'b0 : valid_r;

    if (fire) begin
      valid_nxt = 1'b1;
      step_nxt  = pop ? 3'd0 : step_r + 3'd1;
      if (head.is_quad) begin
        min_nxt  = new_min;
        max_nxt  = new_max;
        any_nxt  = 1'b1;
        data_nxt = '{out_index: idx, index_valid: 1'b1,
                     last_out: head.last && final_step,
                     min_seen: new_min, max_seen: new_max};
      end else begin
        data_nxt = '{out_index: '0, index_valid: 1'b0, last_out: 1'b1,
                     min_seen: any_r ? min_r : '0,
                     max_seen: any_r ? max_r : '0};
      end
      // drop draw statistics once its final word is out
      if (pop && head.last) begin
        min_nxt = '1;
        max_nxt = '0;
        any_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      min_r   <= '1;
      max_r   <= '0;
      any_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      any_r   <= any_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> design/quad_to_triangle_index_converter_unit.sv
`timescale 1ns / 1ps
// Top level of the quad to triangle index converter: config registers, front, queue, back.
// Depends on qtic_pkg, qtic_front, qtic_queue and qtic_back.
//
// Takes one vertex slot word per accepted input and, for every four slots, sends out six
// 16-bit triangle-list indices in the order v0,v1,v2,v0,v2,v3. In indexed mode the slot
// index is the input value (low byte for one-byte sources, low 16 bits otherwise); in
// sequential mode it counts up from start_vertex, loaded on the first slot of a draw.
// A slot marked last inside a partial quad drops the held slots and sends one end-marker
// word (index_valid low, last_out high). Every result word carries the running min and
// max of the indices sent in the current draw (zero before the first); they reset after
// the draw's last word. The front end accepts a slot word in any cycle in which the
// two-entry job queue has room; while a job is queued and out_ready is high, the back
// end drives one result word per cycle through a single output register, so a quad
// gives six words and an end marker one. Configuration writes are always accepted
// (cfg_ready is high); write them only while the block is idle. Writes to unused
// indexes are ignored.
module quad_to_triangle_index_converter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  qtic_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output qtic_pkg::out_word_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qtic_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qtic_pkg::CFG_DATA_W-1:0]   cfg_data
);

  qtic_pkg::cfg_t    cfg_r, cfg_nxt;
  qtic_pkg::job_t    push_job, head;
  qtic_pkg::q_stat_t stat;
  logic              acc, push, pop;

  // config registers: always ready, decode by index
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        qtic_pkg::REG_INDEXED_MODE: cfg_nxt.indexed_mode     = cfg_data[0];
        qtic_pkg::REG_BYTES_CODE:   cfg_nxt.index_bytes_code = cfg_data[1:0];
        qtic_pkg::REG_START_VERTEX: cfg_nxt.start_vertex     = cfg_data;
        default:                    cfg_nxt                  = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{indexed_mode: 1'b0, index_bytes_code: 2'd1, start_vertex: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // accept a slot word whenever the queue can take a job
  assign in_ready = !stat.full;
  assign acc      = in_valid && in_ready;

  qtic_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .acc      (acc),
    .in_word  (in_data),
    .push     (push),
    .push_job (push_job)
  );

  qtic_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  qtic_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/qtic_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the quad to triangle index converter, bound to the top level.
// Depends on qtic_pkg and quad_to_triangle_index_converter_unit.
module qtic_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input qtic_pkg::in_word_t                in_data,
  input logic                              out_valid,
  input logic                              out_ready,
  input qtic_pkg::out_word_t               out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [qtic_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [qtic_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an end marker is a bare last word
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.index_valid |-> out_data.last_out && out_data.out_index == '0)
    else $error("malformed end marker");

  // a real index lies within the reported min and max
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_valid |->
      out_data.min_seen <= out_data.out_index && out_data.out_index <= out_data.max_seen)
    else $error("index outside reported min/max");

endmodule

bind quad_to_triangle_index_converter_unit qtic_checker u_qtic_checker (.*);

>>> dv/quad_to_triangle_index_converter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quad_to_triangle_index_converter_unit: directed and random draws.
// Depends on qtic_pkg and the converter RTL; carries its own predictor of the triangle words.
module quad_to_triangle_index_converter_unit_tb;
  import qtic_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int MAX_GAP = 17;
  localparam int SETTLE_CYCLES = 12;        // front, job queue and output register
  localparam int STUCK_LIMIT = 3000;        // cycles with no word moving on any port
  localparam int PRINT_CAP = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SLOTS = 37;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0] BYTES_TWO = 2'd1;
  localparam logic [1:0] BYTES_FOUR = 2'd2;
  localparam logic [1:0] BYTES_SPARE = 2'd3;
  // slot pick for the six words of a quad: v0,v1,v2,v0,v2,v3 (two bits each, v0 first)
  localparam logic [11:0] TRI_ORDER = {2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  quad_to_triangle_index_converter_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // shadow registers
  logic sh_indexed;
  logic [1:0] sh_bytes;
  logic [IDX_W-1:0] sh_start;

  // predictor draw state
  logic [IDX_W-1:0] quad_held [QUAD_IN];
  logic [1:0] held_count;
  logic [IDX_W-1:0] vertex_counter;
  logic draw_fresh;
  logic [IDX_W-1:0] draw_min;
  logic [IDX_W-1:0] draw_max;
  logic draw_has_index;

  out_word_t tri_words_due [$];
  int mismatches = 0;
  bit calm = 1'b0;                          // no idling on either side while set

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic note_mismatch(input string what, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  function automatic void clear_draw_state();
    held_count = '0;
    draw_fresh = 1'b1;
    draw_min = '1;
    draw_max = '0;
    draw_has_index = 1'b0;
  endfunction

  function automatic out_word_t tri_word(input logic [IDX_W-1:0] idx, input logic ok,
                                         input logic fin);
    out_word_t w;
    w.out_index = idx;
    w.index_valid = ok;
    w.last_out = fin;
    w.min_seen = draw_has_index ? draw_min : '0;
    w.max_seen = draw_has_index ? draw_max : '0;
    return w;
  endfunction

  // Work out the words one accepted slot causes and queue them.
  function automatic void convert_slot(input in_word_t w);
    logic [IDX_W-1:0] v;
    logic [1:0] sel;
    if (draw_fresh) begin
      vertex_counter = sh_start;
      draw_fresh = 1'b0;
    end
    if (sh_indexed) begin
      v = (sh_bytes == BYTES_ONE) ? {8'h00, w.index_value[7:0]} : w.index_value[IDX_W-1:0];
    end else begin
      v = vertex_counter;
    end
    vertex_counter = vertex_counter + 1'b1;
    quad_held[held_count] = v;
    if (held_count == 2'd3) begin
      for (int k = 0; k < QUAD_OUT; k++) begin
        sel = TRI_ORDER[2*k +: 2];
        if (quad_held[sel] < draw_min) draw_min = quad_held[sel];
        if (quad_held[sel] > draw_max) draw_max = quad_held[sel];
        draw_has_index = 1'b1;
        tri_words_due.push_back(tri_word(quad_held[sel], 1'b1,
                                         (k == QUAD_OUT - 1) && w.last_in));
      end
      held_count = '0;
    end else begin
      held_count = held_count + 1'b1;
      // partial quad closed by a last slot: drop it, send a bare end marker
      if (w.last_in) tri_words_due.push_back(tri_word('0, 1'b0, 1'b1));
    end
    if (w.last_in) clear_draw_state();
  endfunction

  // Send one slot word; valid stays high afterwards so the next slot can follow at once.
  task automatic send_slot(input logic [31:0] val, input logic is_last);
    in_word_t w;
    int gap;
    w.index_value = val;
    w.last_in = is_last;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    convert_slot(w);
  endtask

  // Drop valid, hold off until every due word has come, then let the pipe settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tri_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_INDEXED_MODE: sh_indexed = d[0];
      REG_BYTES_CODE:   sh_bytes = d[1:0];
      REG_START_VERTEX: sh_start = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Narrow registers get junk in the unused upper bits of the write data.
  task automatic set_config(input logic indexed, input logic [1:0] bytes_code,
                            input logic [IDX_W-1:0] start);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[0] = indexed;
    write_reg(REG_INDEXED_MODE, d);
    d = CFG_DATA_W'($urandom);
    d[1:0] = bytes_code;
    write_reg(REG_BYTES_CODE, d);
    write_reg(REG_START_VERTEX, start);
  endtask

  // ---------------------------------------------------------------- result side
  initial begin : result_stalls
    int stall;
    forever begin
      stall = pick_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : check_words
    out_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (tri_words_due.size() == 0) begin
        note_mismatch("unexpected word, out_index", '0, out_data.out_index);
      end else begin
        due = tri_words_due.pop_front();
        if (out_data.out_index !== due.out_index)
          note_mismatch("out_index", due.out_index, out_data.out_index);
        if (out_data.index_valid !== due.index_valid)
          note_mismatch("index_valid", IDX_W'(due.index_valid), IDX_W'(out_data.index_valid));
        if (out_data.last_out !== due.last_out)
          note_mismatch("last_out", IDX_W'(due.last_out), IDX_W'(out_data.last_out));
        if (out_data.min_seen !== due.min_seen)
          note_mismatch("min_seen", due.min_seen, out_data.min_seen);
        if (out_data.max_seen !== due.max_seen)
          note_mismatch("max_seen", due.max_seen, out_data.max_seen);
      end
    end
  end

  // Abort when no word has moved on any port for too long.
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
      $display("** quad_to_triangle_index_converter_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // Reset settings: sequential from zero. One quad, then a lone last slot, which
  // gives an end marker with nothing emitted yet in its draw.
  task automatic test_reset_defaults();
    for (int i = 0; i < QUAD_IN; i++) send_slot($urandom, i == QUAD_IN - 1);
    send_slot($urandom, 1'b1);
    wait_idle();
  endtask

  // Indexed mode with bytes codes one, two and the spare code, with extreme raw values.
  task automatic test_index_widths();
    write_reg(REG_UNUSED, '1);
    set_config(1'b1, BYTES_TWO, '0);
    send_slot(32'hFFFF_FFFF, 1'b0);
    send_slot(32'h0000_0000, 1'b0);
    send_slot(32'h0001_0000, 1'b0);
    send_slot(32'h0000_FFFF, 1'b1);
    wait_idle();
    write_reg(REG_BYTES_CODE, {14'h3FFF, BYTES_ONE});
    send_slot(32'hFFFF_FF80, 1'b0);
    send_slot(32'h0000_01FF, 1'b0);
    send_slot(32'hAAAA_5500, 1'b0);
    send_slot(32'h5555_AA7F, 1'b1);
    wait_idle();
    write_reg(REG_BYTES_CODE, {14'h0000, BYTES_SPARE});
    send_slot(32'h8000_0001, 1'b0);
    send_slot(32'h7FFF_FFFE, 1'b0);
    send_slot(32'h1234_5678, 1'b0);
    send_slot(32'hFEDC_BA98, 1'b1);
    wait_idle();
  endtask

  // A quad, then a held slot dropped by last: the marker keeps the draw's min and max.
  task automatic test_partial_quad();
    write_reg(REG_BYTES_CODE, {14'h0000, BYTES_FOUR});
    for (int i = 0; i < QUAD_IN; i++) send_slot($urandom, 1'b0);
    send_slot($urandom, 1'b1);
    wait_idle();
  endtask

  // Counter wraps inside one quad; start_vertex written mid-draw must not reload it.
  task automatic test_counter_wrap();
    set_config(1'b0, BYTES_TWO, 16'hFFFE);
    send_slot($urandom, 1'b0);
    send_slot($urandom, 1'b0);
    wait_idle();
    write_reg(REG_START_VERTEX, 16'h1234);
    send_slot($urandom, 1'b0);
    send_slot($urandom, 1'b1);
    wait_idle();
  endtask

  // Mostly whole draws of full quads with random content; the rest ragged draws and
  // stray last flags. Each phase runs under its own settings, some with no idling.
  task automatic test_random_draws();
    int sent;
    int len;
    logic [31:0] val;
    logic [IDX_W-1:0] start;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph % 3 == 2);
      case ($urandom_range(0, 3))
        0: start = '0;
        1: start = '1;
        2: start = 16'hFFFD;
        default: start = IDX_W'($urandom);
      endcase
      case (ph)
        0: set_config(1'b1, BYTES_FOUR, '0);
        1: set_config(1'b0, BYTES_ONE, '1);
        2: set_config(1'b1, BYTES_ONE, start);
        default: set_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), start);
      endcase
      sent = 0;
      while (sent < PHASE_SLOTS) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9)
                                          : QUAD_IN * $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          val = $urandom;
          if ($urandom_range(0, 1)) val[15:0] = 16'($urandom_range(0, 40));
          send_slot(val, (i == len - 1) || ($urandom_range(0, 29) == 0));
          sent++;
        end
      end
      wait_idle();
    end
    calm = 1'b0;
  endtask

  initial begin
    sh_indexed = 1'b0;
    sh_bytes = BYTES_TWO;
    sh_start = '0;
    vertex_counter = '0;
    clear_draw_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_index_widths();
    test_partial_quad();
    test_counter_wrap();
    test_random_draws();

    wait_idle();
    if (mismatches == 0) begin
      $display("** quad_to_triangle_index_converter_unit: PASSED **");
    end else begin
      $display("** quad_to_triangle_index_converter_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> quad_to_triangle_index_converter_unit.f
design/qtic_pkg.sv
design/qtic_front.sv
design/qtic_queue.sv
design/qtic_back.sv
design/quad_to_triangle_index_converter_unit.sv
design/qtic_checker.sv
dv/quad_to_triangle_index_converter_unit_tb.sv
